[hw/rtl/spst_pkg.sv]
`timescale 1ns / 1ps

package spst_pkg;

  // Fixed field widths of the item channels
  localparam int unsigned POS_W  = 10;
  localparam int unsigned REND_W = 11;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned SIGN_W = 2;

  typedef logic signed [SIGN_W-1:0] sign_t;

  localparam sign_t SIGN_POS  = 2'sb01;
  localparam sign_t SIGN_NEG  = 2'sb11;
  localparam sign_t SIGN_ZERO = 2'sb00;

  typedef enum logic {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_LEAF,
    ST_SET_UP,
    ST_Q_WALK,
    ST_Q_EMIT
  } state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic set_leaf;
    logic set_up;
    logic q_walk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic set_skip;
    logic node_root;
    logic q_done;
  } status_t;

  function automatic sign_t sign_mul(sign_t a, sign_t b);
    sign_t r;
    if (a == SIGN_ZERO || b == SIGN_ZERO) begin
      r = SIGN_ZERO;
    end else if (a[1] ^ b[1]) begin
      r = SIGN_NEG;
    end else begin
      r = SIGN_POS;
    end
    return r;
  endfunction

  function automatic sign_t sign_of(logic signed [VAL_W-1:0] v);
    sign_t r;
    if (v[VAL_W-1]) begin
      r = SIGN_NEG;
    end else if (v != '0) begin
      r = SIGN_POS;
    end else begin
      r = SIGN_ZERO;
    end
    return r;
  endfunction

endpackage

[hw/rtl/spst_ram.sv]
`timescale 1ns / 1ps

// One write port, two registered read ports.
module spst_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr_i,
  output logic [WIDTH-1:0]         rd_a_data_o,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr_i,
  output logic [WIDTH-1:0]         rd_b_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_a_data_o <= mem_q[rd_a_addr_i];
    rd_b_data_o <= mem_q[rd_b_addr_i];
  end

endmodule

[hw/rtl/spst_dp.sv]
`timescale 1ns / 1ps

module spst_dp #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spst_pkg::cmd_t                      cmd_i,
  output spst_pkg::status_t                   status_o,
  input  logic                                operation_i,
  input  logic [spst_pkg::POS_W-1:0]          position_i,
  input  logic [spst_pkg::REND_W-1:0]         right_end_i,
  input  logic signed [spst_pkg::VAL_W-1:0]   new_value_i,
  output logic signed [spst_pkg::SIGN_W-1:0]  product_sign_o
);

  import spst_pkg::*;

  localparam int unsigned NODES  = 2 * LEAVES;
  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned RW     = $clog2(NODES + 1);

  logic [NODE_W-1:0] clr_q, clr_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [RW-1:0]     lo_q, lo_d, hi_q, hi_d;
  sign_t             val_q, val_d, acc_q, acc_d, prod_q, prod_d;
  logic              pend_a_q, pend_a_d, pend_b_q, pend_b_d;

  logic              wr_en;
  logic [NODE_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
  sign_t             wr_data;
  logic [SIGN_W-1:0] rd_a_data, rd_b_data;

  logic [31:0] pos_ext, rend_ext, rend_sat;
  logic        q_empty;
  sign_t       up_prod, fold_a, fold_b;

  spst_ram #(
    .WIDTH(SIGN_W),
    .DEPTH(NODES)
  ) u_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_a_addr_i(rd_a_addr),
    .rd_a_data_o(rd_a_data),
    .rd_b_addr_i(rd_b_addr),
    .rd_b_data_o(rd_b_data)
  );

  // Input decode: saturate right end, flag empty range
  assign pos_ext  = 32'(position_i);
  assign rend_ext = 32'(right_end_i);
  assign rend_sat = (rend_ext > 32'(LEAVES)) ? 32'(LEAVES) : rend_ext;
  assign q_empty  = (pos_ext >= rend_sat);

  assign status_o.clr_last  = (clr_q == NODE_W'(NODES - 1));
  assign status_o.is_query  = (op_e'(operation_i) == OP_QUERY);
  assign status_o.set_skip  = (pos_ext >= 32'(LEAVES));
  assign status_o.node_root = (node_q == NODE_W'(1));
  assign status_o.q_done    = (lo_q >= hi_q);

  assign up_prod = sign_mul(val_q, sign_t'(rd_a_data));
  assign fold_a  = pend_a_q ? sign_t'(rd_a_data) : SIGN_POS;
  assign fold_b  = pend_b_q ? sign_t'(rd_b_data) : SIGN_POS;

  always_comb begin
    clr_d     = clr_q;
    node_d    = node_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    val_d     = val_q;
    prod_d    = prod_q;
    pend_a_d  = 1'b0;
    pend_b_d  = 1'b0;
    acc_d     = sign_mul(sign_mul(acc_q, fold_a), fold_b);
    wr_en     = 1'b0;
    wr_addr   = node_q;
    wr_data   = val_q;
    rd_a_addr = node_q ^ NODE_W'(1);
    rd_b_addr = '0;

    if (cmd_i.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = SIGN_POS;
      clr_d   = clr_q + NODE_W'(1);
    end

    if (cmd_i.load) begin
      node_d = NODE_W'(pos_ext + 32'(LEAVES));
      val_d  = sign_of(new_value_i);
      acc_d  = SIGN_POS;
      if (q_empty) begin
        lo_d = '0;
        hi_d = '0;
      end else begin
        lo_d = RW'(pos_ext + 32'(LEAVES));
        hi_d = RW'(rend_sat + 32'(LEAVES));
      end
    end

    // Leaf write, sibling fetched for the first parent
    if (cmd_i.set_leaf) begin
      wr_en  = 1'b1;
      node_d = node_q >> 1;
    end

    // Parent = own path value times sibling
    if (cmd_i.set_up) begin
      wr_en   = 1'b1;
      wr_data = up_prod;
      val_d   = up_prod;
      node_d  = node_q >> 1;
    end

    // One tree level per cycle; reads folded the cycle after
    if (cmd_i.q_walk && !status_o.q_done) begin
      rd_a_addr = lo_q[NODE_W-1:0];
      rd_b_addr = NODE_W'(hi_q - RW'(1));
      pend_a_d  = lo_q[0];
      pend_b_d  = hi_q[0];
      lo_d      = RW'((lo_q + RW'(lo_q[0])) >> 1);
      hi_d      = hi_q >> 1;
    end

    if (cmd_i.emit) begin
      prod_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      pend_a_q <= 1'b0;
      pend_b_q <= 1'b0;
    end else begin
      clr_q    <= clr_d;
      pend_a_q <= pend_a_d;
      pend_b_q <= pend_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    val_q  <= val_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign product_sign_o = prod_q;

endmodule

[hw/rtl/spst_ctrl.sv]
`timescale 1ns / 1ps

module spst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  spst_pkg::status_t status_i,
  output spst_pkg::cmd_t    cmd_o
);

  import spst_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.is_query) begin
            state_d = ST_Q_WALK;
          end else if (!status_i.set_skip) begin
            state_d = ST_SET_LEAF;
          end
        end
      end
      ST_SET_LEAF: begin
        cmd_o.set_leaf = 1'b1;
        state_d        = ST_SET_UP;
      end
      ST_SET_UP: begin
        cmd_o.set_up = 1'b1;
        if (status_i.node_root) begin
          state_d = ST_IDLE;
        end
      end
      ST_Q_WALK: begin
        cmd_o.q_walk = 1'b1;
        if (status_i.q_done) begin
          state_d = ST_Q_EMIT;
        end
      end
      ST_Q_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/sign_product_segment_tree_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ------------------------------------------
// in        input      in_valid_i/in_ready_o  operation_i, position_i, right_end_i,
//                                             new_value_i
// out       output     out_valid_o/out_ready_i product_sign_o
//
// A set holds in_ready_o low after acceptance: one leaf write, then one parent write per
// level up to the root; the next item is not accepted until the set finishes.
// A query holds it low while it walks both range ends up the tree until they meet, then
// while it folds the last reads and loads the result register; a new item is not
// accepted until the query finishes.
// The tree memory's single write port bounds the set path to one level a cycle.
// After reset a clearing pass writes +1 to all 2*LEAVES nodes, one per cycle;
// in_ready_o stays low for those cycles.
// A result waiting in the output register does not block acceptance; only a
// second query finishing before it is taken holds off in the emit step.

module sign_product_segment_tree_unit #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [spst_pkg::POS_W-1:0]          position_i,
  input  logic [spst_pkg::REND_W-1:0]         right_end_i,
  input  logic signed [spst_pkg::VAL_W-1:0]   new_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [spst_pkg::SIGN_W-1:0]  product_sign_o
);

  import spst_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: clearing pass, leaf update climb, range walk, result handover
  spst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Tree memory, path registers, accumulator and result register
  spst_dp #(
    .LEAVES(LEAVES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .right_end_i   (right_end_i),
    .new_value_i   (new_value_i),
    .product_sign_o(product_sign_o)
  );

endmodule

[hw/rtl/spst_checker.sv]
`timescale 1ns / 1ps

module spst_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                operation_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [spst_pkg::SIGN_W-1:0]  product_sign_o
);

  import spst_pkg::*;

  // A pending result holds until the transaction completes
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(product_sign_o))
    else $error("result dropped or changed while stalled");

  // Only -1, 0 or +1 appear on the result
  a_out_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (product_sign_o == SIGN_POS || product_sign_o == SIGN_NEG ||
                     product_sign_o == SIGN_ZERO))
    else $error("illegal sign code on result");

  // An accepted query keeps the input closed while it walks the tree
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_e'(operation_i) == OP_QUERY) |=> !in_ready_o)
    else $error("input open during query walk");

  // A new result never appears right after an input transaction
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result appeared one cycle after acceptance");

endmodule

bind sign_product_segment_tree_unit spst_checker u_spst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .product_sign_o(product_sign_o)
);

[dv/tb_sign_product_segment_tree_unit.sv]
`timescale 1ns / 1ps

import spst_pkg::*;

// Shadow copy of the tree plus the signs still owed by the block.
class sign_product_board #(int unsigned LEAVES = 1024);
  sign_t tree[2*LEAVES];
  sign_t awaited_signs[$];
  int    fails;
  int    sets_seen;
  int    queries_seen;
  int    empty_queries;
  int    signs_checked;
  int    zero_signs;
  int    neg_signs;

  function new();
    foreach (tree[k]) tree[k] = SIGN_POS;
  endfunction

  function sign_t sign_of_value(logic signed [VAL_W-1:0] v);
    if (v < 0) return SIGN_NEG;
    if (v != 0) return SIGN_POS;
    return SIGN_ZERO;
  endfunction

  function sign_t sign_times(sign_t a, sign_t b);
    int p;
    p = int'(a) * int'(b);
    return sign_t'(p);
  endfunction

  function void write_leaf(int unsigned pos, logic signed [VAL_W-1:0] v);
    int unsigned node;
    if (pos >= LEAVES) return;
    node = pos + LEAVES;
    tree[node] = sign_of_value(v);
    node = node >> 1;
    while (node > 0) begin
      tree[node] = sign_times(tree[2*node], tree[2*node+1]);
      node = node >> 1;
    end
  endfunction

  function sign_t range_product(int unsigned left, int unsigned right);
    int unsigned lo;
    int unsigned hi;
    sign_t       acc_lo;
    sign_t       acc_hi;
    if (right > LEAVES) right = LEAVES;
    if (left >= right) begin
      empty_queries++;
      return SIGN_POS;
    end
    lo = left + LEAVES;
    hi = right + LEAVES;
    acc_lo = SIGN_POS;
    acc_hi = SIGN_POS;
    while (lo < hi) begin
      if (lo[0]) begin
        acc_lo = sign_times(acc_lo, tree[lo]);
        lo++;
      end
      if (hi[0]) begin
        hi--;
        acc_hi = sign_times(tree[hi], acc_hi);
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return sign_times(acc_lo, acc_hi);
  endfunction

  // Called once per accepted input transaction.
  function void note_item(op_e op, logic [POS_W-1:0] pos, logic [REND_W-1:0] rend,
                          logic signed [VAL_W-1:0] v);
    if (op == OP_SET) begin
      sets_seen++;
      write_leaf(pos, v);
    end else begin
      queries_seen++;
      awaited_signs.push_back(range_product(pos, rend));
    end
  endfunction

  function void report_mismatch(string msg);
    if (fails < 30) $display("[%0t] MISMATCH: %s", $time, msg);
    fails++;
  endfunction

  // Called once per accepted output transaction.
  function void check_sign(sign_t got);
    sign_t want;
    if (awaited_signs.size() == 0) begin
      report_mismatch($sformatf("product_sign %0d with no query outstanding", got));
      return;
    end
    want = awaited_signs.pop_front();
    signs_checked++;
    if (want == SIGN_ZERO) zero_signs++;
    if (want == SIGN_NEG) neg_signs++;
    if (got !== want)
      report_mismatch($sformatf("product_sign got %0d, want %0d", got, want));
  endfunction
endclass

module tb_sign_product_segment_tree_unit;

  localparam int unsigned LEAF_COUNT     = 1024;
  localparam int          RANDOM_ITEMS   = 1100;
  // Idle cycles that end the run; the post-reset clearing pass counts as idle.
  localparam int          WATCHDOG_LIMIT = 20000;
  // Lets a set still in flight finish, with a margin.
  localparam int          TAIL_CYCLES    = 40;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     operation_i = OP_SET;
  logic [POS_W-1:0]         position_i = '0;
  logic [REND_W-1:0]        right_end_i = '0;
  logic signed [VAL_W-1:0]  new_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [SIGN_W-1:0] product_sign_o;

  sign_product_board #(LEAF_COUNT) board;

  // When set, neither side inserts gaps: back-to-back stretches.
  bit steady = 1'b0;
  int sink_stall = 0;
  int idle_cycles = 0;

  sign_product_segment_tree_unit #(
    .LEAVES(LEAF_COUNT)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .right_end_i   (right_end_i),
    .new_value_i   (new_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .product_sign_o(product_sign_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output side: random back-pressure, none while steady.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_stall = 0;
    end else if (sink_stall != 0) begin
      sink_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
    end
  end

  // Every completed output transaction is checked against the oldest expectation.
  // Values are sampled at the edge, before the block's registers update.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_sign(product_sign_o);
  end

  // Watchdog: too many consecutive cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog expired, %0d results outstanding", $time,
               board.awaited_signs.size());
      $display("sign_product_segment_tree_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one input transaction and returns at the edge that accepts it.
  // Valid is left high on return, so a zero-gap follow-on needs one assignment only.
  task automatic send_item(input op_e op, input logic [POS_W-1:0] pos,
                           input logic [REND_W-1:0] rend,
                           input logic signed [VAL_W-1:0] v);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    right_end_i <= rend;
    new_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(op, pos, rend, v);
  endtask

  // Sender drops valid and pauses until every owed result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.awaited_signs.size() != 0);
  endtask

  // Positions cluster at both ends so sets and queries keep meeting.
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return POS_W'($urandom_range(0, 63));
    if (r < 70) return POS_W'($urandom_range(960, 1023));
    return POS_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 11) return 16'sh8000;
    if (r < 16) return 16'sh7fff;
    if (r < 21) return -16'sd1;
    if (r < 26) return 16'sd1;
    return VAL_W'($urandom());
  endfunction

  task automatic random_item();
    logic [POS_W-1:0]  pos;
    logic [REND_W-1:0] rend;
    int                r;
    int                span;
    pos = pick_position();
    if ($urandom_range(0, 1) == 0) begin
      send_item(OP_SET, pos, REND_W'($urandom()), pick_value());
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) span = $urandom_range(1, 8);
      else if (r < 75) span = $urandom_range(9, 128);
      else if (r < 85) span = $urandom_range(129, 1024);
      else span = 0;
      if (r >= 85 && r < 89) rend = REND_W'(pos);                          // empty
      else if (r >= 89 && r < 93) rend = REND_W'($urandom_range(0, pos)); // reversed
      else if (r >= 93) rend = REND_W'($urandom_range(1025, 2047));       // past the end
      else if (pos + span > 2047) rend = 11'd2047;
      else rend = REND_W'(pos + span);
      send_item(OP_QUERY, pos, rend, VAL_W'($urandom()));
    end
  endtask

  initial begin
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fresh tree, extremes of every field, saturation, empty and
    // reversed ranges, zero leaves and sign flips at both ends and the middle.
    send_item(OP_QUERY, 10'd0,    11'd1024, 16'sd0);
    send_item(OP_QUERY, 10'd0,    11'd2047, 16'sh7fff);
    send_item(OP_SET,   10'd0,    11'd2047, 16'sh8000);
    send_item(OP_SET,   10'd1023, 11'd0,    16'sh7fff);
    send_item(OP_SET,   10'd5,    11'd1024, 16'sd0);
    send_item(OP_SET,   10'd512,  11'd3,    -16'sd1);
    send_item(OP_SET,   10'd511,  11'd700,  16'sd1);
    send_item(OP_QUERY, 10'd0,    11'd1,    16'sd0);
    send_item(OP_QUERY, 10'd1023, 11'd1024, 16'sd0);
    send_item(OP_QUERY, 10'd0,    11'd1024, 16'sd0);
    send_item(OP_QUERY, 10'd6,    11'd1024, 16'sd0);
    send_item(OP_QUERY, 10'd5,    11'd6,    16'sd0);
    send_item(OP_QUERY, 10'd600,  11'd600,  16'sd0);
    send_item(OP_QUERY, 10'd700,  11'd3,    16'sd0);
    send_item(OP_QUERY, 10'd1023, 11'd2047, 16'sd0);
    send_item(OP_QUERY, 10'd0,    11'd0,    16'sd0);
    send_item(OP_SET,   10'd5,    11'd0,    16'sd12345);
    send_item(OP_QUERY, 10'd0,    11'd1024, 16'sd0);
    send_item(OP_SET,   10'd1000, 11'd0,    -16'sd7);
    send_item(OP_QUERY, 10'd513,  11'd1024, 16'sd0);
    send_item(OP_QUERY, 10'd1,    11'd1023, 16'sd0);
    send_item(OP_SET,   10'd0,    11'd0,    16'sd1);
    send_item(OP_QUERY, 10'd0,    11'd1024, 16'sd0);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 300 && n < 400) || (n >= 800 && n < 870);
      if (n == 550) drain_results();
      random_item();
    end
    steady = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.awaited_signs.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.awaited_signs.size()));

    $display("Covered %0d sets and %0d queries (%0d empty or reversed); %0d signs checked,",
             board.sets_seen, board.queries_seen, board.empty_queries, board.signs_checked);
    $display("%0d of them zero and %0d negative; %0d mismatches.",
             board.zero_signs, board.neg_signs, board.fails);
    if (board.fails == 0) begin
      $display("sign_product_segment_tree_unit regression: pass");
    end else begin
      $display("sign_product_segment_tree_unit regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/spst_pkg.sv
hw/rtl/spst_ram.sv
hw/rtl/spst_dp.sv
hw/rtl/spst_ctrl.sv
hw/rtl/sign_product_segment_tree_unit.sv
hw/rtl/spst_checker.sv
dv/tb_sign_product_segment_tree_unit.sv
